// ===== hdl/lpfp_pkg.sv =====
// Shared types and constants for the length-prefixed field parser.
// No dependencies; imported by lpfp_parse, length_prefixed_field_parser_top and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package lpfp_pkg;

	// Character codes recognized by the parser.
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Width of the header character counter.
	localparam int CNT_W = 5;

	// One result transaction.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic [7:0] field_number;
		logic       field_end;
		logic       packet_done;
		logic       packet_error;
	} res_t;

endpackage

`default_nettype wire

// ===== hdl/lpfp_parse.sv =====
// Parser state (mode, header length, body count, field index) and result logic.
// Depends on lpfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpfp_parse import lpfp_pkg::*; #(
	parameter int LEN_BITS      = 24,
	parameter int MAX_LEN_CHARS = 18
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] in_byte,
	input  wire logic       last_byte,
	output res_t            res,
	output logic            res_valid
);

	localparam logic [1:0] MODE_SKIP   = 2'd0;
	localparam logic [1:0] MODE_HEADER = 2'd1;
	localparam logic [1:0] MODE_BODY   = 2'd2;
	localparam logic [1:0] MODE_DRAIN  = 2'd3;

	localparam int WIDE_W = LEN_BITS + 4;

	logic [1:0]          mode_q, mode_n;
	logic [LEN_BITS-1:0] len_q, len_n;
	logic                digits_q, digits_n;
	logic                ovf_q, ovf_n;
	logic [CNT_W-1:0]    cnt_q, cnt_n;
	logic [LEN_BITS-1:0] rem_q, rem_n;
	logic [7:0]          field_q, field_n;

	logic                is_digit;
	logic [3:0]          digit;
	logic [WIDE_W-1:0]   len_wide;
	logic [WIDE_W-1:0]   len_next_wide;
	logic                len_ovf;
	logic [CNT_W-1:0]    cnt_inc;
	logic [LEN_BITS-1:0] rem_dec;
	logic [7:0]          field_inc;

	assign is_digit  = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
	assign digit     = 4'(in_byte - CH_ZERO);
	assign len_wide  = WIDE_W'(len_q);
	// Times ten as two shifted copies, then add the new digit.
	assign len_next_wide = (len_wide << 3) + (len_wide << 1) + WIDE_W'(digit);
	assign len_ovf   = |len_next_wide[WIDE_W-1:LEN_BITS];
	assign cnt_inc   = cnt_q + CNT_W'(1);
	assign rem_dec   = rem_q - LEN_BITS'(1);
	assign field_inc = (field_q == 8'hFF) ? field_q : field_q + 8'd1;

	always_comb begin
		mode_n    = mode_q;
		len_n     = len_q;
		digits_n  = digits_q;
		ovf_n     = ovf_q;
		cnt_n     = cnt_q;
		rem_n     = rem_q;
		field_n   = field_q;
		res       = '0;
		res.field_number = field_q;
		res_valid = 1'b0;

		case (mode_q)
			MODE_SKIP: begin
				if (in_byte == CH_SPACE || in_byte == CH_CR) begin
					if (last_byte) begin
						res_valid       = 1'b1;
						res.packet_done = 1'b1;
					end
				end else if (in_byte == CH_LF) begin
					res_valid       = 1'b1;
					res.packet_done = 1'b1;
					mode_n          = MODE_DRAIN;
				end else if (is_digit && !last_byte) begin
					mode_n   = MODE_HEADER;
					len_n    = LEN_BITS'(digit);
					digits_n = 1'b1;
					ovf_n    = 1'b0;
					cnt_n    = CNT_W'(1);
				end else begin
					res_valid        = 1'b1;
					res.packet_error = 1'b1;
					mode_n           = MODE_DRAIN;
				end
			end
			MODE_HEADER: begin
				if (in_byte == CH_SPACE) begin
					if (ovf_q) begin
						res_valid        = 1'b1;
						res.packet_error = 1'b1;
						mode_n           = MODE_DRAIN;
					end else if (len_q == '0) begin
						// An empty field closes right at its header.
						res_valid       = 1'b1;
						res.field_end   = 1'b1;
						res.packet_done = last_byte;
						field_n         = field_inc;
						mode_n          = MODE_SKIP;
					end else if (last_byte) begin
						res_valid        = 1'b1;
						res.packet_error = 1'b1;
						mode_n           = MODE_DRAIN;
					end else begin
						rem_n  = len_q;
						mode_n = MODE_BODY;
					end
				end else begin
					if (digits_q && is_digit) begin
						len_n = len_next_wide[LEN_BITS-1:0];
						if (len_ovf) begin
							ovf_n = 1'b1;
						end
					end else begin
						digits_n = 1'b0;
					end
					cnt_n = cnt_inc;
					if (cnt_inc > CNT_W'(MAX_LEN_CHARS) || last_byte) begin
						res_valid        = 1'b1;
						res.packet_error = 1'b1;
						mode_n           = MODE_DRAIN;
					end
				end
			end
			MODE_BODY: begin
				rem_n = rem_dec;
				if (rem_dec == '0) begin
					res_valid       = 1'b1;
					res.data_byte   = in_byte;
					res.byte_valid  = 1'b1;
					res.field_end   = 1'b1;
					res.packet_done = last_byte;
					field_n         = field_inc;
					mode_n          = MODE_SKIP;
				end else if (last_byte) begin
					res_valid        = 1'b1;
					res.packet_error = 1'b1;
					mode_n           = MODE_DRAIN;
				end else begin
					res_valid      = 1'b1;
					res.data_byte  = in_byte;
					res.byte_valid = 1'b1;
				end
			end
			default: begin
				// Drain: ignore bytes until the end of the packet.
			end
		endcase

		// The last byte of a packet returns the parser to its idle state.
		if (last_byte) begin
			mode_n   = MODE_SKIP;
			len_n    = '0;
			digits_n = 1'b1;
			ovf_n    = 1'b0;
			cnt_n    = '0;
			rem_n    = '0;
			field_n  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_SKIP;
			len_q    <= '0;
			digits_q <= 1'b1;
			ovf_q    <= 1'b0;
			cnt_q    <= '0;
			rem_q    <= '0;
			field_q  <= '0;
		end else if (step) begin
			mode_q   <= mode_n;
			len_q    <= len_n;
			digits_q <= digits_n;
			ovf_q    <= ovf_n;
			cnt_q    <= cnt_n;
			rem_q    <= rem_n;
			field_q  <= field_n;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/length_prefixed_field_parser_top.sv =====
// Top level of the length-prefixed field parser: input register, parser, result register.
// Depends on lpfp_pkg and lpfp_parse.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                  Payload
// item      item_valid / item_stall    in_byte, last_byte
// result    result_valid / result_stall data_byte, byte_valid, field_number,
//                                      field_end, packet_done, packet_error
//
// One byte is accepted every cycle unless item_stall is high; its result, if any, is
// loaded into the result register when the byte moves on from the input register.
// The rate is set by the update of the mode, length and body counters, done once per byte.
// A byte that causes no result leaves the result register untouched.
// While the result register holds an untaken transaction and result_stall is high,
// the input register waits and item_stall rises. Reset clears only control state.

module length_prefixed_field_parser_top import lpfp_pkg::*; #(
	parameter int LEN_BITS      = 24,
	parameter int MAX_LEN_CHARS = 18
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       last_byte,
	output logic            result_valid,
	input  wire logic       result_stall,
	output logic [7:0]      data_byte,
	output logic            byte_valid,
	output logic [7:0]      field_number,
	output logic            field_end,
	output logic            packet_done,
	output logic            packet_error
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       valid_s2;
	res_t       res_s2;
	res_t       res;
	logic       res_valid;
	logic       advance;
	logic       accept;

	assign advance    = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	lpfp_parse #(
		.LEN_BITS      (LEN_BITS),
		.MAX_LEN_CHARS (MAX_LEN_CHARS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.in_byte   (byte_s1),
		.last_byte (last_s1),
		.res       (res),
		.res_valid (res_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance && res_valid) begin
				valid_s2 <= 1'b1;
			end else if (valid_s2 && !result_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_byte;
			last_s1 <= last_byte;
		end
		if (advance && res_valid) begin
			res_s2 <= res;
		end
	end

	assign result_valid = valid_s2;
	assign data_byte    = res_s2.data_byte;
	assign byte_valid   = res_s2.byte_valid;
	assign field_number = res_s2.field_number;
	assign field_end    = res_s2.field_end;
	assign packet_done  = res_s2.packet_done;
	assign packet_error = res_s2.packet_error;

endmodule

`default_nettype wire

// ===== tb/length_prefixed_field_parser_top_test.sv =====
// Self-checking testbench for length_prefixed_field_parser_top: a directed byte table,
// then random packets; results are checked against typed rows or a behavioral model.
// Depends on lpfp_pkg and the RTL of length_prefixed_field_parser_top.
`timescale 1ns / 1ps

module length_prefixed_field_parser_top_test;
	import lpfp_pkg::*;

	localparam int LEN_BITS      = 24;
	localparam int MAX_LEN_CHARS = 18;
	localparam int ITEM_TARGET   = 1750;
	localparam int LIMIT_NS      = 4_000_000;

	typedef enum logic [1:0] {SKIP_SEPS, IN_HEADER, IN_BODY, DRAINING} parse_mode_e;

	typedef struct packed {
		logic [7:0] b;
		logic       last;
		bit         typed;
		bit         has_res;
		res_t       res;
	} stim_row_t;

	logic       clk;
	logic       arst_n;
	logic       item_valid;
	logic       item_stall;
	logic [7:0] in_byte;
	logic       last_byte;
	logic       result_valid;
	logic       result_stall;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic [7:0] field_number;
	logic       field_end;
	logic       packet_done;
	logic       packet_error;

	// Parser model state.
	parse_mode_e         mode;
	logic [LEN_BITS-1:0] len_val;
	bit                  digits_on;
	bit                  len_ovf;
	logic [4:0]          hdr_chars;
	logic [LEN_BITS-1:0] body_left;
	logic [7:0]          field_idx;

	res_t        pending_results[$];
	stim_row_t   dir_rows[$];
	logic [7:0]  pkt[$];
	int unsigned mismatch_count = 0;
	int unsigned items_counted = 0;
	bit          tx_calm = 0;

	length_prefixed_field_parser_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.in_byte      (in_byte),
		.last_byte    (last_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.data_byte    (data_byte),
		.byte_valid   (byte_valid),
		.field_number (field_number),
		.field_end    (field_end),
		.packet_done  (packet_done),
		.packet_error (packet_error)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic res_t make_res(input logic [7:0] data, input logic valid,
			input logic [7:0] fnum, input logic fend, input logic done, input logic err);
		return {data, valid, fnum, fend, done, err};
	endfunction

	task automatic reset_parser();
		mode      = SKIP_SEPS;
		len_val   = '0;
		digits_on = 1'b1;
		len_ovf   = 1'b0;
		hdr_chars = '0;
		body_left = '0;
		field_idx = '0;
	endtask

	// Advances the parser model by one byte and returns the result it causes, if any.
	task automatic parse_byte(input logic [7:0] b, input logic last, output bit got,
			output res_t r);
		bit              is_digit;
		bit              bad;
		longint unsigned wide;
		is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
		bad = 1'b0;
		got = 1'b0;
		r = '0;
		r.field_number = field_idx;
		case (mode)
			SKIP_SEPS: begin
				if (b == CH_SPACE || b == CH_CR) begin
					if (last) begin
						got = 1'b1;
						r.packet_done = 1'b1;
					end
				end else if (b == CH_LF) begin
					got = 1'b1;
					r.packet_done = 1'b1;
					mode = DRAINING;
				end else if (is_digit && !last) begin
					mode = IN_HEADER;
					len_val = LEN_BITS'(b - CH_ZERO);
					digits_on = 1'b1;
					len_ovf = 1'b0;
					hdr_chars = 5'd1;
				end else begin
					bad = 1'b1;
				end
			end
			IN_HEADER: begin
				if (b == CH_SPACE) begin
					if (len_ovf || (last && len_val != 0)) begin
						bad = 1'b1;
					end else if (len_val == 0) begin
						got = 1'b1;
						r.field_end = 1'b1;
						r.packet_done = last;
						if (field_idx != 8'hFF) field_idx++;
						mode = SKIP_SEPS;
					end else begin
						body_left = len_val;
						mode = IN_BODY;
					end
				end else begin
					// Only the leading digits count; anything after them is carried along.
					if (digits_on && is_digit) begin
						wide = 64'(len_val) * 10 + 64'(b - CH_ZERO);
						if (wide > (64'd1 << LEN_BITS) - 1) len_ovf = 1'b1;
						len_val = wide[LEN_BITS-1:0];
					end else begin
						digits_on = 1'b0;
					end
					hdr_chars = hdr_chars + 5'd1;
					if (hdr_chars > MAX_LEN_CHARS || last) bad = 1'b1;
				end
			end
			IN_BODY: begin
				body_left = body_left - 1'b1;
				if (body_left == 0) begin
					got = 1'b1;
					r.data_byte = b;
					r.byte_valid = 1'b1;
					r.field_end = 1'b1;
					r.packet_done = last;
					if (field_idx != 8'hFF) field_idx++;
					mode = SKIP_SEPS;
				end else if (last) begin
					bad = 1'b1;
				end else begin
					got = 1'b1;
					r.data_byte = b;
					r.byte_valid = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (bad) begin
			got = 1'b1;
			r.packet_error = 1'b1;
			mode = DRAINING;
		end
		if (last) reset_parser();
	endtask

	function automatic int unsigned idle_len();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 85) return $urandom_range(1, 3);
		if (p < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// A transaction starts at the falling edge and is held until accepted.
	task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
			input bit has_res, input res_t typed_res);
		int unsigned gap;
		bit          got;
		res_t        r;
		if ($urandom_range(0, 149) == 0) tx_calm = !tx_calm;
		gap = tx_calm ? 0 : idle_len();
		@(negedge clk);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		in_byte <= b;
		last_byte <= last;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		items_counted++;
		parse_byte(b, last, got, r);
		if (typed) begin
			got = has_res;
			r = typed_res;
		end
		if (got) pending_results.insert(pending_results.size(), r);
	endtask

	task automatic send_packet();
		foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1, 1'b0, 1'b0, '0);
	endtask

	task automatic pkt_add(input logic [7:0] c);
		pkt.insert(pkt.size(), c);
	endtask

	task automatic row_model(input logic [7:0] b, input logic last);
		dir_rows.insert(dir_rows.size(), {b, last, 1'b0, 1'b0, res_t'(0)});
	endtask

	task automatic row_typed(input logic [7:0] b, input logic last, input bit has_res,
			input res_t res);
		dir_rows.insert(dir_rows.size(), {b, last, 1'b1, has_res, res});
	endtask

	function automatic logic [7:0] sep_char();
		return $urandom_range(0, 1) ? CH_SPACE : CH_CR;
	endfunction

	// A byte that is neither a digit nor a space; optionally not CR or LF either.
	function automatic logic [7:0] stray_char(input bit no_ctrl);
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(0, 255));
		end while (c == CH_SPACE || (c >= CH_ZERO && c <= CH_NINE) ||
			(no_ctrl && (c == CH_CR || c == CH_LF)));
		return c;
	endfunction

	function automatic int unsigned rand_field_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
	endfunction

	// Appends one well-formed field, sometimes with separators, leading zeros or
	// trailing junk in its header.
	task automatic add_field(input int unsigned blen);
		logic [7:0]  digs[$];
		int unsigned v;
		if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) pkt_add(sep_char());
		v = blen;
		do begin
			digs.push_front(8'(CH_ZERO + v % 10));
			v = v / 10;
		end while (v != 0);
		if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) digs.push_front(CH_ZERO);
		if ($urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 3)) digs.insert(digs.size(), stray_char(0));
		foreach (digs[i]) pkt_add(digs[i]);
		pkt_add(CH_SPACE);
		repeat (blen) pkt_add(8'($urandom_range(0, 255)));
	endtask

	task automatic flag_mismatch(input string what, input logic [7:0] seen,
			input logic [7:0] want);
		$display("%0t ns: %s mismatch, got %h, expected %h", $time, what, seen, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("unexpected transaction", data_byte, 8'h00);
			end else begin
				want = pending_results.pop_front();
				if (data_byte !== want.data_byte)
					flag_mismatch("data_byte", data_byte, want.data_byte);
				if (byte_valid !== want.byte_valid)
					flag_mismatch("byte_valid", byte_valid, want.byte_valid);
				if (field_number !== want.field_number)
					flag_mismatch("field_number", field_number, want.field_number);
				if (field_end !== want.field_end)
					flag_mismatch("field_end", field_end, want.field_end);
				if (packet_done !== want.packet_done)
					flag_mismatch("packet_done", packet_done, want.packet_done);
				if (packet_error !== want.packet_error)
					flag_mismatch("packet_error", packet_error, want.packet_error);
			end
		end
	end

	// The receiver stalls in bursts, with calm stretches between.
	initial begin
		int unsigned hold;
		bit          rx_calm;
		rx_calm = 1'b0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
			if (!rx_calm && $urandom_range(0, 3) == 0) begin
				hold = idle_len() + 1;
				result_stall <= 1'b1;
				repeat (hold) @(negedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	initial begin
		string       ovf_digits;
		int unsigned blen;
		int          pick;
		arst_n = 1'b0;
		item_valid = 1'b0;
		in_byte = 8'h00;
		last_byte = 1'b0;
		reset_parser();

		// Newline alone, then a bad first character.
		row_typed(CH_LF, 1, 1, make_res(8'h00, 0, 8'd0, 0, 1, 0));
		row_typed(8'h78, 1, 1, make_res(8'h00, 0, 8'd0, 0, 0, 1));
		// Empty field closing on the last byte.
		row_typed(CH_ZERO, 0, 0, '0);
		row_typed(CH_SPACE, 1, 1, make_res(8'h00, 0, 8'd0, 1, 1, 0));
		// Two body bytes at the byte extremes, the field ending with the packet.
		row_typed(8'h32, 0, 0, '0);
		row_typed(CH_SPACE, 0, 0, '0);
		row_typed(8'h00, 0, 1, make_res(8'h00, 1, 8'd0, 0, 0, 0));
		row_typed(8'hFF, 1, 1, make_res(8'hFF, 1, 8'd0, 1, 1, 0));
		// A digit cannot start a field on the last byte.
		row_typed(CH_NINE, 1, 1, make_res(8'h00, 0, 8'd0, 0, 0, 1));
		// Separators only.
		row_typed(CH_SPACE, 0, 0, '0);
		row_typed(CH_CR, 1, 1, make_res(8'h00, 0, 8'd0, 0, 1, 0));
		// Packet cut inside a header.
		row_typed(8'h31, 0, 0, '0);
		row_typed(8'h32, 1, 1, make_res(8'h00, 0, 8'd0, 0, 0, 1));
		// Junk after the digits, then a body cut short.
		row_model(8'h33, 0);
		row_model(8'h23, 0);
		row_model(CH_SPACE, 0);
		row_model(8'h61, 0);
		row_model(8'h62, 1);
		// Length one above the counter range.
		ovf_digits = "16777216";
		for (int i = 0; i < ovf_digits.len(); i++) row_typed(ovf_digits[i], 0, 0, '0);
		row_typed(CH_SPACE, 1, 1, make_res(8'h00, 0, 8'd0, 0, 0, 1));

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_byte(dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed,
				dir_rows[i].has_res, dir_rows[i].res);

		// One packet long enough for the field index to saturate.
		pkt.delete();
		repeat (258) add_field(($urandom_range(0, 5) == 0) ? 1 : 0);
		send_packet();

		while (items_counted < ITEM_TARGET) begin
			pkt.delete();
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				repeat ($urandom_range(1, 5)) add_field(rand_field_len());
				case ($urandom_range(0, 2))
					0: begin
						if ($urandom_range(0, 1)) pkt_add(sep_char());
						pkt_add(CH_LF);
						repeat ($urandom_range(0, 3)) pkt_add(8'($urandom_range(0, 255)));
					end
					1: begin
					end
					default: repeat ($urandom_range(1, 2)) pkt_add(sep_char());
				endcase
			end else if (pick < 90) begin
				repeat ($urandom_range(0, 2)) add_field(rand_field_len());
				case ($urandom_range(0, 3))
					0: pkt_add(stray_char(1));
					1: begin
						// Header one or more characters past the limit.
						pkt_add(8'($urandom_range(CH_ZERO, CH_NINE)));
						repeat ($urandom_range(MAX_LEN_CHARS, MAX_LEN_CHARS + 3))
							pkt_add($urandom_range(0, 1) ?
								8'($urandom_range(CH_ZERO, CH_NINE)) : stray_char(0));
						pkt_add(CH_SPACE);
					end
					2: begin
						// At least twenty million, well past the counter range.
						pkt_add(8'($urandom_range(8'h32, CH_NINE)));
						repeat ($urandom_range(7, 10))
							pkt_add(8'($urandom_range(CH_ZERO, CH_NINE)));
						pkt_add(CH_SPACE);
					end
					default: begin
						blen = $urandom_range(1, 8);
						add_field(blen);
						repeat ($urandom_range(1, blen + 1)) void'(pkt.pop_back());
					end
				endcase
				repeat ($urandom_range(0, 3)) pkt_add(8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 6)) pkt_add(8'($urandom_range(0, 255)));
			end
			send_packet();
		end

		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
